[rtl/dthd_pkg.sv]
// ----------------------------------------------------------------------------
// dthd_pkg
// shared types, constants and helpers of the diagonal to hacked diagonal
// compactor
// ----------------------------------------------------------------------------
package dthd_pkg;

   // largest hack the row buffer holds
   localparam int HACK_MAX   = 32;
   localparam int ROW_IDX_W  = (HACK_MAX > 1) ? $clog2(HACK_MAX) : 1;
   localparam int ROW_CNT_W  = $clog2(HACK_MAX + 1);

   localparam int VALUE_W    = 64;
   localparam int OFFSET_W   = 32;
   localparam int INDEX_W    = 32;
   localparam int HSIZE_W    = 6;
   localparam int EBYTES_W   = 4;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   typedef logic [ROW_IDX_W-1:0]  row_idx_type;
   typedef logic [ROW_CNT_W-1:0]  row_cnt_type;
   typedef logic [INDEX_W-1:0]    index_type;
   typedef logic [VALUE_W-1:0]    value_type;
   typedef logic [HSIZE_W-1:0]    hsize_type;
   typedef logic [EBYTES_W-1:0]   ebytes_type;

   localparam hsize_type  HACK_SIZE_RESET  = 6'd32;
   localparam ebytes_type ELEM_BYTES_RESET = 4'd8;

   // result word kinds
   typedef enum logic [1:0] {
      KIND_VALUE = 2'd0,
      KIND_DIAG  = 2'd1,
      KIND_HACK  = 2'd2
   } kind_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HACK_SIZE     = 1'b0,
      REG_ELEMENT_BYTES = 1'b1
   } reg_index_type;

   // zero acts as one, anything above the buffer depth is clamped
   function automatic row_cnt_type eff_hack(input hsize_type hs);
      row_cnt_type res;
      if (hs == '0) begin
         res = row_cnt_type'(1);
      end else if (32'(hs) > HACK_MAX) begin
         res = row_cnt_type'(HACK_MAX);
      end else begin
         res = row_cnt_type'(hs);
      end
      return res;
   endfunction

   // keeps the low element_bytes bytes, all eight above eight
   function automatic value_type byte_mask(input ebytes_type eb);
      value_type m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (32'(eb) > i) begin
            m[i*8 +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

endpackage

[rtl/dthd_req_if.sv]
// ----------------------------------------------------------------------------
// dthd_req_if
// element channel: one diagonal element per word with its framing flags
// ----------------------------------------------------------------------------
interface dthd_req_if;
   logic                                valid;
   logic                                ready;
   logic [dthd_pkg::VALUE_W-1:0]        value_bits;
   logic signed [dthd_pkg::OFFSET_W-1:0] diag_offset;
   logic                                last_row;
   logic                                last_diag;

   modport source (
      output valid, value_bits, diag_offset, last_row, last_diag,
      input  ready
   );
   modport sink (
      input  valid, value_bits, diag_offset, last_row, last_diag,
      output ready
   );
endinterface

[rtl/dthd_rsp_if.sv]
// ----------------------------------------------------------------------------
// dthd_rsp_if
// result channel: packed values, diagonal offset entries and hack offsets
// ----------------------------------------------------------------------------
interface dthd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           kind;
   logic [dthd_pkg::INDEX_W-1:0]         index;
   logic [dthd_pkg::VALUE_W-1:0]         out_value;
   logic signed [dthd_pkg::OFFSET_W-1:0] out_offset;
   logic                                 last;

   modport source (
      output valid, kind, index, out_value, out_offset, last,
      input  ready
   );
   modport sink (
      input  valid, kind, index, out_value, out_offset, last,
      output ready
   );
endinterface

[rtl/dthd_ram.sv]
// ----------------------------------------------------------------------------
// dthd_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module dthd_ram #(
   parameter int Width = 64,
   parameter int Depth = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                             rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dia_to_hacked_dia_compactor.sv]
// ----------------------------------------------------------------------------
// dia_to_hacked_dia_compactor
// turns a diagonal format sparse matrix stream into hacked diagonal entries
// ----------------------------------------------------------------------------
// output: the entry of a kept diagonal is registered in ST_DIAG once the element
//    that ends it is taken; each buffered value then follows (ram read, then output
//    register load), then the hack offset on a hack end; each load waits for a free output register
// throughput: one element per cycle for elements that do not end a diagonal; an
//    ending element holds the input while its kept words and any hack offset are loaded
// reset: synchronous; hack_size 32, element_bytes 8, counters cleared; the row
//    buffer ram is not cleared, rows are always written before they are read
// ----------------------------------------------------------------------------
module dia_to_hacked_dia_compactor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [dthd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dthd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   dthd_req_if.sink                           req_ch,
   dthd_rsp_if.source                         rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIAG,
      ST_READ,
      ST_VALUE,
      ST_HACK
   } state_type;

   state_type                 state_ff, state_in;

   // configuration registers
   dthd_pkg::hsize_type       hack_size_ff, hack_size_in;
   dthd_pkg::ebytes_type      elem_bytes_ff, elem_bytes_in;

   // current diagonal
   dthd_pkg::row_cnt_type     rows_ff, rows_in;
   logic                      nz_ff, nz_in;
   logic [dthd_pkg::OFFSET_W-1:0] doff_ff, doff_in;
   logic                      ldiag_ff, ldiag_in;
   dthd_pkg::row_idx_type     rd_row_ff, rd_row_in;

   // running counters
   dthd_pkg::index_type       kept_ff, kept_in;
   dthd_pkg::index_type       vbase_ff, vbase_in;
   dthd_pkg::index_type       hack_num_ff, hack_num_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   dthd_pkg::kind_type        rsp_kind_ff, rsp_kind_in;
   dthd_pkg::index_type       rsp_index_ff, rsp_index_in;
   dthd_pkg::value_type       rsp_value_ff, rsp_value_in;
   logic [dthd_pkg::OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic                      rsp_last_ff, rsp_last_in;

   dthd_pkg::row_cnt_type     hs_eff;
   dthd_pkg::row_cnt_type     rows_inc;
   dthd_pkg::value_type       masked;
   dthd_pkg::value_type       rd_data;
   logic                      req_fire;
   logic                      rsp_free;
   logic                      diag_end;
   logic                      nz_next;
   logic                      is_last_row;

   // row buffer: one diagonal's rows of the current hack
   dthd_ram #(
      .Width (dthd_pkg::VALUE_W),
      .Depth (dthd_pkg::HACK_MAX)
   ) u_row_buf (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (rows_ff[dthd_pkg::ROW_IDX_W-1:0]),
      .wr_data (masked),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (rd_row_ff),
      .rd_data (rd_data)
   );

   // input is taken only between diagonal emissions
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // output register may load when empty or being drained this cycle
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign hs_eff       = dthd_pkg::eff_hack(hack_size_ff);
   assign masked       = req_ch.value_bits & dthd_pkg::byte_mask(elem_bytes_ff);
   assign rows_inc     = rows_ff + dthd_pkg::row_cnt_type'(1);
   // diagonal closes on its last row or once the hack is full
   assign diag_end     = req_ch.last_row || (rows_inc >= hs_eff);
   assign nz_next      = nz_ff || (masked != '0);
   assign is_last_row  = (dthd_pkg::row_cnt_type'(rd_row_ff)
                          == (rows_ff - dthd_pkg::row_cnt_type'(1)));

   always_comb begin
      state_in      = state_ff;
      hack_size_in  = hack_size_ff;
      elem_bytes_in = elem_bytes_ff;
      rows_in       = rows_ff;
      nz_in         = nz_ff;
      doff_in       = doff_ff;
      ldiag_in      = ldiag_ff;
      rd_row_in     = rd_row_ff;
      kept_in       = kept_ff;
      vbase_in      = vbase_ff;
      hack_num_in   = hack_num_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_last_in   = rsp_last_ff;

      // configuration writes, to be issued only while idle; the block itself does not enforce it
      if (csr_we) begin
         case (csr_index)
            dthd_pkg::REG_HACK_SIZE: begin
               hack_size_in = csr_wdata[dthd_pkg::HSIZE_W-1:0];
            end
            dthd_pkg::REG_ELEMENT_BYTES: begin
               elem_bytes_in = csr_wdata[dthd_pkg::EBYTES_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rows_in  = rows_inc;
               nz_in    = nz_next;
               doff_in  = req_ch.diag_offset;
               ldiag_in = req_ch.last_diag;
               if (diag_end) begin
                  if (nz_next) begin
                     state_in = ST_DIAG;
                  end else begin
                     // all-zero diagonal is dropped
                     rows_in  = '0;
                     nz_in    = 1'b0;
                     state_in = req_ch.last_diag ? ST_HACK : ST_IDLE;
                  end
               end
            end
         end
         ST_DIAG: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = dthd_pkg::KIND_DIAG;
               rsp_index_in  = kept_ff;
               rsp_value_in  = '0;
               rsp_offset_in = doff_ff;
               rsp_last_in   = 1'b0;
               rd_row_in     = '0;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            // ram read issued this cycle, data next cycle
            state_in = ST_VALUE;
         end
         ST_VALUE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = dthd_pkg::KIND_VALUE;
               rsp_index_in  = vbase_ff + dthd_pkg::index_type'(rd_row_ff);
               rsp_value_in  = rd_data;
               rsp_offset_in = '0;
               rsp_last_in   = is_last_row && !ldiag_ff;
               if (is_last_row) begin
                  kept_in  = kept_ff + dthd_pkg::index_type'(1);
                  vbase_in = vbase_ff + dthd_pkg::index_type'(hs_eff);
                  rows_in  = '0;
                  nz_in    = 1'b0;
                  state_in = ldiag_ff ? ST_HACK : ST_IDLE;
               end else begin
                  rd_row_in = rd_row_ff + dthd_pkg::row_idx_type'(1);
                  state_in  = ST_READ;
               end
            end
         end
         ST_HACK: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = dthd_pkg::KIND_HACK;
               rsp_index_in  = hack_num_ff + dthd_pkg::index_type'(1);
               rsp_value_in  = '0;
               rsp_offset_in = kept_ff;
               rsp_last_in   = 1'b1;
               hack_num_in   = hack_num_ff + dthd_pkg::index_type'(1);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hack_size_ff  <= dthd_pkg::HACK_SIZE_RESET;
         elem_bytes_ff <= dthd_pkg::ELEM_BYTES_RESET;
         rows_ff       <= '0;
         nz_ff         <= 1'b0;
         rd_row_ff     <= '0;
         kept_ff       <= '0;
         vbase_ff      <= '0;
         hack_num_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hack_size_ff  <= hack_size_in;
         elem_bytes_ff <= elem_bytes_in;
         rows_ff       <= rows_in;
         nz_ff         <= nz_in;
         rd_row_ff     <= rd_row_in;
         kept_ff       <= kept_in;
         vbase_ff      <= vbase_in;
         hack_num_ff   <= hack_num_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // payload, no reset needed
      doff_ff       <= doff_in;
      ldiag_ff      <= ldiag_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_kind_ff;
   assign rsp_ch.index      = rsp_index_ff;
   assign rsp_ch.out_value  = rsp_value_ff;
   assign rsp_ch.out_offset = rsp_offset_ff;
   assign rsp_ch.last       = rsp_last_ff;

   // buffered row count never runs past the buffer
   a_rows_bound: assert property (@(posedge clock) disable iff (reset)
      32'(rows_ff) <= dthd_pkg::HACK_MAX)
      else $error("row count past buffer depth");

   // a dropped diagonal with no hack end goes straight back to taking words
   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && diag_end && !nz_next && !req_ch.last_diag) |=> (state_ff == ST_IDLE))
      else $error("dropped diagonal did not return to idle");

   // a hack offset word always closes its element's results
   a_hack_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.kind == dthd_pkg::KIND_HACK)) |-> rsp_ch.last)
      else $error("hack offset word without last");

   // emission of a kept diagonal never starts with an empty buffer
   a_diag_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIAG) |-> (rows_ff != '0) && nz_ff)
      else $error("diagonal emission with nothing buffered");

endmodule

[bench/dia_to_hacked_dia_compactor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dia_to_hacked_dia_compactor_tb
// self-checking bench for the diagonal to hacked diagonal compactor. element
// words are driven hack by hack with random gaps on both channels, each
// accepted element is run through a local model of the compaction, and every
// result word is matched in order against the words that model expects
// ----------------------------------------------------------------------------
module dia_to_hacked_dia_compactor_tb;

   localparam int unsigned RANDOM_ITEMS  = 480;
   localparam int unsigned DRAIN_LIMIT   = 5000;  // cycles to wait for outstanding words
   localparam int unsigned SETTLE_CYCLES = 8;     // block may still be busy on a dropped diagonal

   // one result word as the block should produce it
   typedef struct packed {
      dthd_pkg::kind_type  kind;
      dthd_pkg::index_type slot;
      dthd_pkg::value_type bits;
      logic signed [31:0]  offs;
      logic                last;
   } hd_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [dthd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [dthd_pkg::CSR_DATA_W-1:0] csr_wdata;

   dthd_req_if req_if ();
   dthd_rsp_if rsp_if ();

   dia_to_hacked_dia_compactor dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if)
   );

   // words still owed by the block, oldest first
   hd_word_type expected_words[$];
   int unsigned fail_count = 0;
   bit req_calm = 1'b0;   // no gaps between element words while set

   // local copy of the compaction state and registers
   logic [5:0]          cfg_hack_size  = dthd_pkg::HACK_SIZE_RESET;
   logic [3:0]          cfg_elem_bytes = dthd_pkg::ELEM_BYTES_RESET;
   dthd_pkg::value_type row_store[dthd_pkg::HACK_MAX];
   int unsigned         rows_held = 0;
   bit                  any_live  = 1'b0;
   dthd_pkg::index_type kept_diags = '0;   // running hack offset
   dthd_pkg::index_type slot_base  = '0;   // kept_diags times rows per hack
   dthd_pkg::index_type hacks_done = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous bound on the whole run
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   // rows per hack as the block applies it: zero acts as one, clamp at the buffer depth
   function automatic int unsigned rows_per_hack();
      if (cfg_hack_size == 6'd0) return 1;
      if (cfg_hack_size > dthd_pkg::HACK_MAX) return dthd_pkg::HACK_MAX;
      return 32'(cfg_hack_size);
   endfunction

   // bytes that take part in the nonzero test and are passed on
   function automatic dthd_pkg::value_type low_bytes_mask(input logic [3:0] eb);
      if (eb >= 4'd8) return '1;
      return (64'd1 << {eb, 3'b000}) - 64'd1;
   endfunction

   // works out the words one accepted element causes and queues them
   task automatic predict_compaction(input dthd_pkg::value_type bits,
                                     input logic [31:0] offs,
                                     input logic row_end, input logic diag_end);
      int unsigned         hs;
      dthd_pkg::value_type kept;
      hd_word_type         burst[$];
      hd_word_type         w;
      hs   = rows_per_hack();
      kept = bits & low_bytes_mask(cfg_elem_bytes);
      row_store[rows_held % dthd_pkg::HACK_MAX] = kept;
      if (kept != 64'd0) any_live = 1'b1;
      rows_held++;
      // a diagonal closes on its last row or once the hack is full
      if (!row_end && rows_held < hs) return;
      if (any_live) begin
         w = '{dthd_pkg::KIND_DIAG, kept_diags, 64'd0, offs, 1'b0};
         burst.insert(burst.size(), w);
         for (int r = 0; r < rows_held; r++) begin
            w = '{dthd_pkg::KIND_VALUE, slot_base + dthd_pkg::index_type'(r), row_store[r],
                  32'sd0, 1'b0};
            burst.insert(burst.size(), w);
         end
         kept_diags++;
         slot_base += dthd_pkg::index_type'(hs);
      end
      rows_held = 0;
      any_live  = 1'b0;
      // the hack end flag only counts on an element that closes a diagonal
      if (diag_end) begin
         hacks_done++;
         w = '{dthd_pkg::KIND_HACK, hacks_done, 64'd0, kept_diags, 1'b0};
         burst.insert(burst.size(), w);
      end
      if (burst.size() != 0) begin
         burst[burst.size()-1].last = 1'b1;
         foreach (burst[i]) expected_words.insert(expected_words.size(), burst[i]);
      end
   endtask

   // drives one element word and waits for the handshake
   task automatic send_element(input dthd_pkg::value_type bits,
                               input logic signed [31:0] offs,
                               input logic row_end, input logic diag_end);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.value_bits  <= bits;
      req_if.diag_offset <= offs;
      req_if.last_row    <= row_end;
      req_if.last_diag   <= diag_end;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      predict_compaction(bits, offs, row_end, diag_end);
   endtask

   // stops the element channel and waits until every owed word is back
   task automatic drain();
      int unsigned waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_words.size() != 0) begin
         $display("%0t: %0d expected words never arrived, next kind %0d slot %0d",
                  $time, expected_words.size(), expected_words[0].kind,
                  expected_words[0].slot);
         fail_count++;
         expected_words.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes both registers back to back once the block is idle
   task automatic configure(input logic [5:0] hs_data, input logic [5:0] eb_data);
      drain();
      csr_we    <= 1'b1;
      csr_index <= dthd_pkg::REG_HACK_SIZE;
      csr_wdata <= hs_data;
      @(posedge clock);
      csr_index <= dthd_pkg::REG_ELEMENT_BYTES;
      csr_wdata <= eb_data;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_hack_size  = hs_data;
      cfg_elem_bytes = eb_data[3:0];
   endtask

   // result side: random stalls per word, every accepted word checked in order
   initial begin : result_sink
      int unsigned hold;
      int unsigned taken;
      bit          rsp_calm;
      hd_word_type got;
      hd_word_type want;
      taken    = 0;
      rsp_calm = 1'b0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // now and then a stretch with ready held high
         if (taken % 48 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         hold = rsp_calm ? 0 : $urandom_range(0, 12);
         if (hold != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (rsp_if.valid !== 1'b1) @(posedge clock);
         taken++;
         got = '{dthd_pkg::kind_type'(rsp_if.kind), rsp_if.index, rsp_if.out_value,
                 rsp_if.out_offset, rsp_if.last};
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word kind %0d slot %0d value %h offset %0d last %0b",
                     $time, got.kind, got.slot, got.bits, got.offs, got.last);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               $write("%0t: word mismatch, expected kind %0d slot %0d value %h offset %0d",
                      $time, want.kind, want.slot, want.bits, want.offs);
               $write(" last %0b, got kind %0d slot %0d value %h offset %0d",
                      want.last, got.kind, got.slot, got.bits, got.offs);
               $display(" last %0b", got.last);
               fail_count++;
            end
         end
      end
   end

   // reset values: full hack of 32 rows, all eight bytes; top byte only and
   // offset extremes, short diagonal closed by its last row
   task automatic test_reset_defaults();
      send_element(64'h8000_0000_0000_0000, 32'sh7fff_ffff, 1'b0, 1'b0);
      send_element(64'h0, 32'sd0, 1'b0, 1'b0);
      send_element(64'hffff_ffff_ffff_ffff, 32'sh8000_0000, 1'b1, 1'b1);
   endtask

   // hack size zero acts as one row: every element closes a diagonal
   task automatic test_single_row_hacks();
      configure(6'd0, 6'd8);
      send_element(64'h0, 32'sd5, 1'b0, 1'b1);       // dropped, hack end still reported
      send_element(64'h1, -32'sd1, 1'b0, 1'b0);
   endtask

   // element width: none, clamped above eight, and a single byte
   task automatic test_element_width();
      configure(6'd4, 6'd0);
      send_element(64'hffff_ffff_ffff_ffff, 32'sd3, 1'b1, 1'b1);   // never kept
      configure(6'd4, 6'd15);
      send_element(64'h8000_0000_0000_0000, 32'sd7, 1'b1, 1'b0);
      configure(6'd4, 6'd1);
      send_element(64'h0000_0000_0000_ff00, 32'sd9, 1'b1, 1'b0);   // only upper bytes set
      send_element(64'hffff_ffff_ffff_ff01, -32'sd9, 1'b1, 1'b1);
   endtask

   // hack end flag on elements that do not close a diagonal is ignored
   task automatic test_stray_hack_end();
      configure(6'd4, 6'd8);
      for (int r = 0; r < 4; r++) begin
         send_element({$urandom, $urandom}, 32'($urandom), 1'b0, 1'b1);
      end
   endtask

   // shrink the hack while a diagonal is half buffered, then clamp a large size
   task automatic test_resize_mid_diagonal();
      configure(6'd8, 6'd8);
      for (int r = 0; r < 3; r++) begin
         send_element({$urandom, $urandom}, 32'sd11, 1'b0, 1'b1);
      end
      configure(6'd2, 6'd8);
      send_element({$urandom, $urandom}, 32'sd12, 1'b0, 1'b1);      // four rows held, closes
      configure(6'd63, 6'd8);
      send_element(64'h0, 32'sd13, 1'b0, 1'b0);
      send_element(64'h55, 32'sd14, 1'b1, 1'b1);
   endtask

   // phases of random settings, mostly well-formed hacks with some stray words;
   // a phase may stop inside a diagonal so the next setting lands mid-diagonal
   task automatic test_random_hacks();
      int unsigned         sent;
      int unsigned         phase_items;
      int unsigned         n;
      int unsigned         hs;
      int unsigned         rows;
      int unsigned         n_diags;
      int unsigned         fill;
      int unsigned         pick;
      logic [5:0]          hs_data;
      logic [3:0]          eb_data;
      logic [31:0]         offs;
      dthd_pkg::value_type rnd;
      dthd_pkg::value_type bits;
      logic                row_end;
      logic                diag_flag;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // small hacks most of the time, a few full and oversized ones
         pick = $urandom_range(0, 15);
         if (pick == 0)      hs_data = 6'd0;
         else if (pick == 1) hs_data = 6'($urandom_range(33, 63));
         else if (pick < 4)  hs_data = 6'($urandom_range(9, 32));
         else                hs_data = 6'($urandom_range(1, 8));
         pick = $urandom_range(0, 9);
         if (pick == 0)      eb_data = 4'd0;
         else if (pick == 1) eb_data = 4'($urandom_range(9, 15));
         else                eb_data = 4'($urandom_range(1, 8));
         configure(hs_data, {2'($urandom), eb_data});
         req_calm    = ($urandom_range(0, 3) == 0);
         phase_items = $urandom_range(20, 70);
         hs = rows_per_hack();
         n  = 0;
         while (n < phase_items) begin
            if ($urandom_range(0, 9) == 0) begin
               // stray word with arbitrary framing
               send_element({$urandom, $urandom}, 32'($urandom),
                            $urandom_range(0, 3) == 0, 1'($urandom));
               n++;
            end else begin
               n_diags = $urandom_range(1, 4);
               rows    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, hs) : hs;
               for (int d = 0; d < n_diags; d++) begin
                  fill = $urandom_range(0, 3);
                  offs = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 64)) - 32'd32
                                                     : 32'($urandom);
                  for (int r = 0; r < rows; r++) begin
                     rnd = {$urandom, $urandom};
                     case (fill)
                        0: bits = 64'd0;                                  // dropped diagonal
                        1: bits = rnd & ~low_bytes_mask(cfg_elem_bytes); // only ignored bytes
                        2: bits = ($urandom_range(0, 3) == 0) ? rnd : 64'd0;
                        default: bits = ($urandom_range(0, 15) == 0) ? '1 : rnd;
                     endcase
                     // a short hack must mark its last row, a full one may
                     if (r == rows - 1) row_end = (rows < hs) ? 1'b1 : 1'($urandom);
                     else               row_end = 1'b0;
                     if (d == n_diags - 1 && r == rows - 1) diag_flag = 1'b1;
                     else diag_flag = ($urandom_range(0, 7) == 0);
                     send_element(bits, offs, row_end, diag_flag);
                  end
                  n += rows;
               end
            end
         end
         sent += n;
      end
   endtask

   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= dthd_pkg::REG_HACK_SIZE;
      csr_wdata           <= '0;
      req_if.valid        <= 1'b0;
      req_if.value_bits   <= '0;
      req_if.diag_offset  <= '0;
      req_if.last_row     <= 1'b0;
      req_if.last_diag    <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_single_row_hacks();
      test_element_width();
      test_stray_hack_end();
      test_resize_mid_diagonal();
      test_random_hacks();

      drain();
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
